### sv/fitch_pkg.sv
// ----------------------------------------------------------------------------
// Fitch state-set engine package
// Shared widths, operation codes, controller command bundle and the state
// mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fitch_pkg;

    localparam int SET_W    = 16;
    localparam int SCORE_W  = 10;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 5;
    localparam int STATES   = 16;
    localparam int NODES    = 1024;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int SUM_W    = SCORE_W + 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DOWN = 2'd1;
    localparam logic [1:0] OP_UP   = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the item and issue the first reads
        logic fetch;    // capture first read data, issue the right child read
        logic exec;     // combine, write back and present the result
    } t_dp_cmd;

    // Bit i is set when state i is in use.
    function automatic logic [SET_W-1:0] state_mask(input logic [COUNT_W-1:0] count);
        logic [SET_W-1:0] m;
        m = '0;
        for (int i = 0; i < SET_W; i++) begin
            m[i] = (int'(count) > i) && (i < STATES);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### sv/fitch_state_set_engine.sv
// ----------------------------------------------------------------------------
// Fitch state-set engine
// Per-node Fitch downpass and uppass sets with subtree scores, driven one
// node item at a time.
// ----------------------------------------------------------------------------
// Result: o_valid is registered from the execute state, which follows the
//   accept state, or the fetch state for an uppass item; the result transfers
//   at the edge that ends the o_valid cycle. A new item is held off by busy
//   until the last has executed; an uppass needs a second downpass-store read.
// Reset: the controller returns to idle and state_count becomes 16; the node
//   stores are not cleared. The receiver cannot stall the result.
`default_nettype none

module fitch_state_set_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Command channel: a transfer takes place when start is high and busy low.
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_node_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_left_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_right_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_ancestor_index,
    input  wire logic [fitch_pkg::SET_W-1:0]     i_tip_set,
    // State count register; the user must write it only while the engine is idle, the block does not enforce it.
    input  wire logic                            i_cfg_we,
    input  wire logic [fitch_pkg::COUNT_W-1:0]   i_cfg_wdata,
    // Result: each transfer lasts exactly one cycle, marked by o_valid.
    output logic                                 o_valid,
    output logic [fitch_pkg::SET_W-1:0]          o_down_set,
    output logic [fitch_pkg::SET_W-1:0]          o_up_set,
    output logic [fitch_pkg::SCORE_W-1:0]        o_subtree_score
);

    fitch_pkg::t_dp_cmd cmd;

    // The controller walks each item through accept, an optional second
    // fetch for uppass, and execute, where load, down and up items write back.
    fitch_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // The datapath owns the three node stores. Each item finishes its write
    // before the next is accepted, so a parent always sees its children's
    // freshly written sets without any forwarding.
    fitch_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_node_index     (i_node_index),
        .i_left_index     (i_left_index),
        .i_right_index    (i_right_index),
        .i_ancestor_index (i_ancestor_index),
        .i_tip_set        (i_tip_set),
        .o_valid          (o_valid),
        .o_down_set       (o_down_set),
        .o_up_set         (o_up_set),
        .o_subtree_score  (o_subtree_score)
    );

endmodule

`default_nettype wire

### sv/fitch_ctrl.sv
// ----------------------------------------------------------------------------
// Fitch engine controller
// Sequences each item through accept, an optional second fetch and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module fitch_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        i_opcode,
    output fitch_pkg::t_dp_cmd     o_cmd,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.fetch  = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    // Uppass needs a fourth set, so it takes a second read.
                    n_state = (i_opcode == fitch_pkg::OP_UP) ? S_FETCH : S_EXEC;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### sv/fitch_dp.sv
// ----------------------------------------------------------------------------
// Fitch engine datapath
// Holds the node stores and the state count, and combines the sets.
// ----------------------------------------------------------------------------
`default_nettype none

module fitch_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fitch_pkg::t_dp_cmd              i_cmd,
    input  wire logic                            i_cfg_we,
    input  wire logic [fitch_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_node_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_left_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_right_index,
    input  wire logic [fitch_pkg::INDEX_W-1:0]   i_ancestor_index,
    input  wire logic [fitch_pkg::SET_W-1:0]     i_tip_set,
    output logic                                 o_valid,
    output logic [fitch_pkg::SET_W-1:0]          o_down_set,
    output logic [fitch_pkg::SET_W-1:0]          o_up_set,
    output logic [fitch_pkg::SCORE_W-1:0]        o_subtree_score
);

    localparam int AW = fitch_pkg::ADDR_W;
    localparam int SW = fitch_pkg::SET_W;
    localparam int CW = fitch_pkg::SCORE_W;

    logic [SW-1:0] down_mem  [fitch_pkg::NODES];
    logic [SW-1:0] up_mem    [fitch_pkg::NODES];
    logic [CW-1:0] score_mem [fitch_pkg::NODES];

    logic [fitch_pkg::COUNT_W-1:0] r_state_count;

    logic [1:0]    r_op;
    logic [AW-1:0] r_nd;
    logic [AW-1:0] r_rc;
    logic [SW-1:0] r_tip;

    logic [SW-1:0] r_down_a, r_down_b, r_up_q;
    logic [CW-1:0] r_score_a, r_score_b;

    // Uppass operands held over the second read.
    logic [SW-1:0] r_f, r_l, r_p;
    logic [CW-1:0] r_score_nd;

    logic          r_valid;
    logic [SW-1:0] r_out_down, r_out_up;
    logic [CW-1:0] r_out_score;

    logic [AW-1:0] down_addr_a, down_addr_b, up_addr, score_addr_a, score_addr_b;
    logic          rd_en;

    logic [SW-1:0] mask;
    logic [SW-1:0] ma, mb, mu;
    logic [SW-1:0] both, dn_set, common, up_res;
    logic          change;
    logic [fitch_pkg::SUM_W-1:0] sum;
    logic [CW-1:0] dn_score;

    logic          we_down, we_up, we_score;
    logic [SW-1:0] wd_down, wd_up;
    logic [CW-1:0] wd_score;
    logic [SW-1:0] n_out_down, n_out_up;
    logic [CW-1:0] n_out_score;

    assign mask  = fitch_pkg::state_mask(r_state_count);
    assign rd_en = i_cmd.accept | i_cmd.fetch;

    // Read addressing: ports at accept, the right child at the second fetch.
    always_comb begin
        down_addr_a  = i_node_index[AW-1:0];
        down_addr_b  = i_left_index[AW-1:0];
        up_addr      = i_node_index[AW-1:0];
        score_addr_a = i_node_index[AW-1:0];
        score_addr_b = i_right_index[AW-1:0];
        if (i_cmd.fetch) begin
            down_addr_a = r_rc;
        end else begin
            if (i_opcode == fitch_pkg::OP_DOWN) begin
                down_addr_a  = i_left_index[AW-1:0];
                down_addr_b  = i_right_index[AW-1:0];
                score_addr_a = i_left_index[AW-1:0];
            end
            if (i_opcode == fitch_pkg::OP_UP) begin
                up_addr = i_ancestor_index[AW-1:0];
            end
        end
    end

    // Set combination.
    always_comb begin
        ma     = r_down_a & mask;
        mb     = r_down_b & mask;
        mu     = r_up_q & mask;
        both   = ma & mb;
        change = (both == '0);
        dn_set = change ? (ma | mb) : both;
        sum    = fitch_pkg::SUM_W'(r_score_a) + fitch_pkg::SUM_W'(r_score_b)
               + fitch_pkg::SUM_W'(change);
        dn_score = (sum > fitch_pkg::SUM_W'(fitch_pkg::SCORE_MAX)) ?
                   fitch_pkg::SCORE_MAX : sum[CW-1:0];
        // In execute of an uppass the right child sits on port A.
        common = r_f & r_p;
        if ((common != '0) && (common == r_p)) begin
            up_res = common;
        end else if ((r_l & ma) == '0) begin
            up_res = r_f | r_p;
        end else begin
            up_res = r_f | (r_p & (r_l | ma));
        end
        up_res = up_res & mask;
    end

    always_comb begin
        we_down     = 1'b0;
        we_up       = 1'b0;
        we_score    = 1'b0;
        wd_down     = dn_set;
        wd_up       = dn_set;
        wd_score    = dn_score;
        n_out_down  = dn_set;
        n_out_up    = dn_set;
        n_out_score = dn_score;
        unique case (r_op)
            fitch_pkg::OP_LOAD: begin
                we_down     = i_cmd.exec;
                we_up       = i_cmd.exec;
                we_score    = i_cmd.exec;
                wd_down     = r_tip & mask;
                wd_up       = r_tip & mask;
                wd_score    = '0;
                n_out_down  = r_tip & mask;
                n_out_up    = r_tip & mask;
                n_out_score = '0;
            end
            fitch_pkg::OP_DOWN: begin
                we_down  = i_cmd.exec;
                we_up    = i_cmd.exec;
                we_score = i_cmd.exec;
            end
            fitch_pkg::OP_UP: begin
                we_up       = i_cmd.exec;
                wd_up       = up_res;
                n_out_down  = r_f;
                n_out_up    = up_res;
                n_out_score = r_score_nd;
            end
            fitch_pkg::OP_READ: begin
                n_out_down  = ma;
                n_out_up    = mu;
                n_out_score = r_score_a;
            end
            default: begin
                n_out_down = dn_set;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_down) begin
            down_mem[r_nd] <= wd_down;
        end
        if (rd_en) begin
            r_down_a <= down_mem[down_addr_a];
            r_down_b <= down_mem[down_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_up) begin
            up_mem[r_nd] <= wd_up;
        end
        if (rd_en) begin
            r_up_q <= up_mem[up_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_score) begin
            score_mem[r_nd] <= wd_score;
        end
        if (rd_en) begin
            r_score_a <= score_mem[score_addr_a];
            r_score_b <= score_mem[score_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_nd  <= i_node_index[AW-1:0];
            r_rc  <= i_right_index[AW-1:0];
            r_tip <= i_tip_set;
        end
        if (i_cmd.fetch) begin
            r_f        <= r_down_a & mask;
            r_l        <= r_down_b & mask;
            r_p        <= r_up_q & mask;
            r_score_nd <= r_score_a;
        end
        if (i_cmd.exec) begin
            r_out_down  <= n_out_down;
            r_out_up    <= n_out_up;
            r_out_score <= n_out_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= fitch_pkg::COUNT_RESET;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_state_count <= i_cfg_wdata;
            end
            r_valid <= i_cmd.exec;
        end
    end

    assign o_valid         = r_valid;
    assign o_down_set      = r_out_down;
    assign o_up_set        = r_out_up;
    assign o_subtree_score = r_out_score;

endmodule

`default_nettype wire

### sv/fitch_chk.sv
// ----------------------------------------------------------------------------
// Fitch engine port checker
// Timing checks on the command and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fitch_chk (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic       o_valid
);

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after a transfer in");

    a_short_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode != fitch_pkg::OP_UP)) |-> ##2 o_valid)
        else $error("result missing two cycles after transfer in");

    a_up_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == fitch_pkg::OP_UP)) |-> ##3 o_valid)
        else $error("uppass result missing three cycles after transfer in");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while engine busy");

endmodule

bind fitch_state_set_engine fitch_chk u_fitch_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid)
);

`default_nettype wire
